// ===== rtl/staf_pkg.sv =====
// Shared types, constants and key tables for the scan code decoder with character queue.
// No dependencies; every other file of the block imports this package.
package staf_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CHAR_W      = 8;
    localparam int KEY_W       = 7;
    localparam int COUNT_W     = 8;
    localparam int KEY_TABLE_LEN = 89;

    localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'd42;
    localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'd54;
    localparam logic [KEY_W-1:0] KEY_ALT    = 7'd56;
    localparam logic [KEY_W-1:0] KEY_CTRL   = 7'd29;

    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [CHAR_W-1:0] scan_byte;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  read_char;
        logic               read_valid;
        logic               dropped;
        logic [COUNT_W-1:0] queued_count;
        logic               shift_held;
        logic               alt_held;
        logic               ctrl_held;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } staf_cmd_t;

    localparam logic [CHAR_W-1:0] LOWER_KEYS [0:KEY_TABLE_LEN-1] = '{
        8'd0,   8'd27,
        8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,  8'd48,
        8'd39,  8'd126, 8'd8,
        8'd9,   8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd121, 8'd117, 8'd105, 8'd111,
        8'd112, 8'd0,   8'd43,  8'd13,  8'd0,
        8'd97,  8'd115, 8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd92,
        8'd0,   8'd0,   8'd0,   8'd0,
        8'd122, 8'd120, 8'd99,  8'd118, 8'd98,  8'd110, 8'd109, 8'd44,  8'd46,  8'd45,
        8'd0,   8'd0,   8'd0,   8'd32,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,
        8'd55,  8'd56,  8'd57,  8'd45,
        8'd52,  8'd53,  8'd54,  8'd43,
        8'd49,  8'd50,  8'd51,  8'd48,
        8'd46,  8'd0,   8'd0,   8'd0,
        8'd0,   8'd0
    };

    localparam logic [CHAR_W-1:0] UPPER_KEYS [0:KEY_TABLE_LEN-1] = '{
        8'd0,   8'd27,
        8'd33,  8'd34,  8'd35,  8'd36,  8'd37,  8'd38,  8'd47,  8'd40,  8'd41,  8'd61,
        8'd63,  8'd92,  8'd8,
        8'd9,   8'd81,  8'd87,  8'd69,  8'd82,  8'd84,  8'd89,  8'd85,  8'd73,  8'd79,
        8'd80,  8'd0,   8'd42,  8'd13,  8'd0,
        8'd65,  8'd83,  8'd68,  8'd70,  8'd71,  8'd72,  8'd74,  8'd75,  8'd76,  8'd64,
        8'd0,   8'd0,   8'd0,   8'd0,
        8'd90,  8'd88,  8'd67,  8'd86,  8'd66,  8'd78,  8'd77,  8'd59,  8'd58,  8'd95,
        8'd0,   8'd0,   8'd0,   8'd32,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,
        8'd55,  8'd56,  8'd57,  8'd45,
        8'd52,  8'd53,  8'd54,  8'd43,
        8'd49,  8'd50,  8'd51,  8'd48,
        8'd46,  8'd0,   8'd0,   8'd0,
        8'd0,   8'd0
    };

    // Returns the ASCII character for a key, or 0 when the key has none.
    function automatic logic [CHAR_W-1:0] key_to_char(input logic [KEY_W-1:0] key,
                                                      input logic shift);
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if (int'(key) < KEY_TABLE_LEN)
        begin
            ch = shift ? UPPER_KEYS[key] : LOWER_KEYS[key];
        end
        if (ch[CHAR_W-1])
        begin
            ch = '0;
        end
        return ch;
    endfunction

endpackage

// ===== rtl/staf_ctrl.sv =====
// Controller for the scan code decoder: sequences capture, execute and output load.
// Depends on staf_pkg for the command struct.
module staf_ctrl
    import staf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output staf_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    // The output register can take a new word when it is empty or being drained.
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.capture = (state_reg == ST_IDLE) && in_valid;
        cmd.exec    = (state_reg == ST_EXEC);
        cmd.load    = (state_reg == ST_LOAD) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/staf_datapath.sv =====
// Datapath for the scan code decoder: key tables, modifier flags, character queue
// and output register. Depends on staf_pkg.
module staf_datapath
    import staf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  staf_cmd_t cmd,
    input  in_word_t  in_word,
    output out_word_t out_word
);

    logic [CHAR_W-1:0] char_mem [0:QUEUE_DEPTH-1];
    logic [CHAR_W-1:0] rd_data_reg;

    in_word_t          in_reg;
    out_word_t         out_reg;
    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] tail_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              shift_reg;
    logic              alt_reg;
    logic              ctrl_reg;
    logic              popped_reg;
    logic              dropped_reg;

    logic [KEY_W-1:0]  key;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] push_val;
    logic              is_scan;
    logic              is_press;
    logic              is_release;
    logic              is_shift_key;
    logic              full;
    logic              empty;
    logic              do_push;
    logic              do_pop;
    logic              lost;

    assign key          = in_reg.scan_byte[KEY_W-1:0];
    assign ch           = key_to_char(key, shift_reg);
    assign is_scan      = (in_reg.func == FUNC_SCAN) && (in_reg.scan_byte != '0);
    assign is_press     = is_scan && !in_reg.scan_byte[CHAR_W-1];
    assign is_release   = is_scan && in_reg.scan_byte[CHAR_W-1];
    assign is_shift_key = (key == KEY_LSHIFT) || (key == KEY_RSHIFT);
    assign full         = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign empty        = (fill_reg == '0);
    // A key without a character is queued as its own 7-bit code.
    assign push_val     = (ch != '0) ? ch : {1'b0, key};
    assign do_push      = cmd.exec && is_press && !full;
    assign lost         = is_press && full;
    assign do_pop       = cmd.exec && (in_reg.func == FUNC_POP) && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            char_mem[tail_reg] <= push_val;
        end
        if (do_pop)
        begin
            rd_data_reg <= char_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_word;
        end
        if (cmd.load)
        begin
            out_reg.read_char    <= popped_reg ? rd_data_reg : '0;
            out_reg.read_valid   <= popped_reg;
            out_reg.dropped      <= dropped_reg;
            out_reg.queued_count <= COUNT_W'(fill_reg);
            out_reg.shift_held   <= shift_reg;
            out_reg.alt_held     <= alt_reg;
            out_reg.ctrl_held    <= ctrl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            shift_reg   <= 1'b0;
            alt_reg     <= 1'b0;
            ctrl_reg    <= 1'b0;
            popped_reg  <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            popped_reg  <= do_pop;
            dropped_reg <= lost;
            if (do_push)
            begin
                tail_reg <= (tail_reg == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop)
            begin
                head_reg <= (head_reg == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end
            // Modifiers are set only by presses that have no character entry.
            if (is_press && (ch == '0))
            begin
                if (is_shift_key)
                begin
                    shift_reg <= 1'b1;
                end
                else if (key == KEY_ALT)
                begin
                    alt_reg <= 1'b1;
                end
                else if (key == KEY_CTRL)
                begin
                    ctrl_reg <= 1'b1;
                end
            end
            else if (is_release)
            begin
                if (is_shift_key)
                begin
                    shift_reg <= 1'b0;
                end
                else if (key == KEY_ALT)
                begin
                    alt_reg <= 1'b0;
                end
                else if (key == KEY_CTRL)
                begin
                    ctrl_reg <= 1'b0;
                end
            end
        end
    end

    assign out_word = out_reg;

endmodule

// ===== rtl/scancode_to_ascii_fifo.sv =====
// Top level of the scan code set 1 decoder with character queue.
// Instantiates staf_ctrl and staf_datapath; depends on staf_pkg.
//
// Each input word either delivers one set 1 scan code byte (func = 0) or pops one
// queued entry (func = 1), and produces exactly one output word. A word passes through
// capture, execute (table lookup plus at most one queue write or one queue read, the
// read data being registered) and load into the output register; the block takes no
// new word until the load is done, and the load waits while an earlier output word
// has not been taken. The queue memory has no reset and needs no clearing pass.
module scancode_to_ascii_fifo
    import staf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    staf_cmd_t cmd;

    staf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    staf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_word  (in_word),
        .out_word (out_word)
    );

endmodule
